// ===== hw/rtl/glos_pkg.sv =====
package glos_pkg;

  localparam int CoordW = 10;
  localparam int ErrW   = 12;
  localparam int CfgW   = 9;

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [CfgW-1:0] CFG_RESET = 9'd256;

  typedef enum logic [1:0] {
    OUT_CLEAR    = 2'd0,
    OUT_BLOCKED  = 2'd1,
    OUT_OFF_GRID = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DELTA,
    ST_SETUP,
    ST_WALK,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic delta;
    logic setup;
    logic step;
  } glos_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oob;
    logic more;
    logic hit;
    logic fin;
  } glos_sts_t;

endpackage

// ===== hw/rtl/glos_datapath.sv =====
module glos_datapath import glos_pkg::*; #(
  parameter int GRID_SIDE = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic                     opcode_i,
  input  logic [7:0]               start_x_i,
  input  logic [7:0]               start_y_i,
  input  logic signed [9:0]        end_x_i,
  input  logic signed [9:0]        end_y_i,
  input  logic                     cell_value_i,
  input  glos_cmd_t                cmd_i,
  output glos_sts_t                sts_o
);

  localparam int Depth = GRID_SIDE * GRID_SIDE;
  localparam int AddrW = $clog2(Depth);
  localparam logic [CoordW:0] SideC = (CoordW + 1)'(GRID_SIDE);

  logic [CfgW-1:0] gw_q, gh_q;
  logic [CoordW:0] wlim, hlim;
  logic            oob_d, oob_q;

  logic [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [CoordW:0]   dx, dy;
  logic [CoordW-1:0] adx_q, ady_q;
  logic              xneg_q, yneg_q;

  logic              steep;
  logic [CoordW-1:0] da, db;
  logic [CoordW-1:0] a_q, a2_q, b_q;
  logic              swap_q, sbneg_q, more_q;
  logic signed [ErrW-1:0] d_q, inc_flat_q, inc_diag_q;

  logic [CoordW-1:0] cx, cy;
  logic              cin;
  logic [AddrW-1:0]  rd_addr;
  logic              rd_vld_q, rd_last_q, rd_in_q, rd_bit_q;

  logic [AddrW-1:0]  clr_cnt_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_wa;
  logic              mem_wd;
  logic              grid_mem_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= CFG_RESET;
      gh_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_WIDTH) begin
        gw_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_IDX_HEIGHT) begin
        gh_q <= cfg_data_i;
      end
    end
  end

  assign wlim = ({2'b00, gw_q} > SideC) ? SideC : {2'b00, gw_q};
  assign hlim = ({2'b00, gh_q} > SideC) ? SideC : {2'b00, gh_q};

  assign oob_d = end_x_i[9] || ({2'b00, end_x_i[8:0]} >= wlim)
              || end_y_i[9] || ({2'b00, end_y_i[8:0]} >= hlim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oob_q <= 1'b0;
    end else if (cmd_i.load) begin
      oob_q <= oob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q <= {2'b00, start_x_i};
      sy_q <= {2'b00, start_y_i};
      ex_q <= {1'b0, end_x_i[8:0]};
      ey_q <= {1'b0, end_y_i[8:0]};
    end
  end

  assign dx = {1'b0, ex_q} - {1'b0, sx_q};
  assign dy = {1'b0, ey_q} - {1'b0, sy_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.delta) begin
      adx_q  <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
      ady_q  <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
      xneg_q <= dx[CoordW];
      yneg_q <= dy[CoordW];
    end
  end

  // steep lines run along y; the walk always goes toward the larger major coordinate
  assign steep = ady_q > adx_q;
  assign da    = steep ? ady_q : adx_q;
  assign db    = steep ? adx_q : ady_q;

  assign cx  = swap_q ? b_q : a_q;
  assign cy  = swap_q ? a_q : b_q;
  assign cin = ({1'b0, cx} < SideC) && ({1'b0, cy} < SideC);
  assign rd_addr = AddrW'(int'(cx) * GRID_SIDE + int'(cy));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      more_q   <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.step;
      if (cmd_i.setup) begin
        more_q <= 1'b1;
      end else if (cmd_i.step) begin
        more_q <= (a_q != a2_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      swap_q     <= steep;
      sbneg_q    <= xneg_q ^ yneg_q;
      inc_flat_q <= $signed(ErrW'({db, 1'b0}));
      inc_diag_q <= $signed(ErrW'({db, 1'b0})) - $signed(ErrW'({da, 1'b0}));
      d_q        <= $signed(ErrW'({db, 1'b0})) - $signed(ErrW'(da));
      if (steep) begin
        a_q  <= yneg_q ? ey_q : sy_q;
        a2_q <= yneg_q ? sy_q : ey_q;
        b_q  <= yneg_q ? ex_q : sx_q;
      end else begin
        a_q  <= xneg_q ? ex_q : sx_q;
        a2_q <= xneg_q ? sx_q : ex_q;
        b_q  <= xneg_q ? ey_q : sy_q;
      end
    end else if (cmd_i.step) begin
      a_q <= a_q + 1'b1;
      if (d_q[ErrW-1] || (d_q == '0)) begin
        d_q <= d_q + inc_flat_q;
      end else begin
        d_q <= d_q + inc_diag_q;
        b_q <= sbneg_q ? b_q - 1'b1 : b_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rd_bit_q  <= grid_mem_q[rd_addr];
      rd_in_q   <= cin;
      rd_last_q <= (a_q == a2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_q;
    mem_wd = 1'b0;
    if (cmd_i.clr) begin
      mem_we = 1'b1;
    end else if (cmd_i.load && (opcode_i == OPC_WRITE)
                 && (int'(start_x_i) < GRID_SIDE) && (int'(start_y_i) < GRID_SIDE)) begin
      mem_we = 1'b1;
      mem_wa = AddrW'(int'(start_x_i) * GRID_SIDE + int'(start_y_i));
      mem_wd = cell_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem_q[mem_wa] <= mem_wd;
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == AddrW'(Depth - 1));
  assign sts_o.oob      = oob_q;
  assign sts_o.more     = more_q;
  assign sts_o.hit      = rd_vld_q && rd_in_q && rd_bit_q;
  assign sts_o.fin      = rd_vld_q && rd_last_q;

endmodule

// ===== hw/rtl/glos_ctrl.sv =====
module glos_ctrl import glos_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       opcode_i,
  output logic       s_tready_o,
  input  logic       m_tready_i,
  output logic       m_tvalid_o,
  output logic [1:0] outcome_o,
  input  glos_sts_t  sts_i,
  output glos_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  outcome_e    res_q, res_d;
  outcome_e    out_q, out_d;
  logic        mvld_q, mvld_d;
  logic        out_free;

  assign out_free = !mvld_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      res_q   <= OUT_CLEAR;
      out_q   <= OUT_CLEAR;
      mvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      out_q   <= out_d;
      mvld_q  <= mvld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    out_d      = out_q;
    mvld_d     = mvld_q && !m_tready_i;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          if (opcode_i == OPC_QUERY) begin
            state_d = ST_DELTA;
          end
        end
      end
      ST_DELTA: begin
        cmd_o.delta = 1'b1;
        if (sts_i.oob) begin
          res_d   = OUT_OFF_GRID;
          state_d = ST_RESP;
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.step = sts_i.more;
        if (sts_i.hit) begin
          res_d   = OUT_BLOCKED;
          state_d = ST_RESP;
        end else if (sts_i.fin) begin
          res_d   = OUT_CLEAR;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_d   = res_q;
          mvld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid_o = mvld_q;
  assign outcome_o  = out_q;

`ifndef NO_ASSERTIONS
  a_query_goes_to_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && s_tvalid_i && opcode_i == OPC_QUERY) |=> state_q == ST_DELTA)
    else $error("query accept did not start the walk");
  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && s_tvalid_i && opcode_i == OPC_WRITE) |=> state_q == ST_IDLE)
    else $error("write item left idle");
  a_hit_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && sts_i.hit) |=> (state_q == ST_RESP && res_q == OUT_BLOCKED))
    else $error("obstacle hit not reported");
  a_resp_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_free) |=> (mvld_q && out_q == $past(res_q)))
    else $error("result not loaded into output stage");
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!s_tready_o && !cmd_o.load && !cmd_o.step))
    else $error("activity during clearing pass");
`endif

endmodule

// ===== hw/rtl/grid_line_of_sight_check.sv =====
// Write item: taken with no result; the next item can follow at once.
// Query item: an off-grid end is answered without a walk; otherwise the walk covers
//   n = max(|dx|, |dy|) + 1 cells, one grid memory read per cell (less on a hit).
// Result waits in an output register; the next item is taken while it waits.
// Reset is asynchronous, active low; afterwards a clearing pass zeroes all GRID_SIDE^2
//   cells of the grid, one cell a cycle, while no item is taken.
module grid_line_of_sight_check import glos_pkg::*; #(
  parameter int GRID_SIDE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_x[7:0], start_y[15:8], end_x[25:16], end_y[35:26], cell_value[36]
  input  logic [39:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // outcome[1:0]
  output logic [7:0]  m_axis_tdata
);

  glos_cmd_t  cmd;
  glos_sts_t  sts;
  logic [1:0] outcome;

  glos_datapath #(
    .GRID_SIDE(GRID_SIDE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .opcode_i    (s_axis_tuser),
    .start_x_i   (s_axis_tdata[7:0]),
    .start_y_i   (s_axis_tdata[15:8]),
    .end_x_i     (s_axis_tdata[25:16]),
    .end_y_i     (s_axis_tdata[35:26]),
    .cell_value_i(s_axis_tdata[36]),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  glos_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .opcode_i  (s_axis_tuser),
    .s_tready_o(s_axis_tready),
    .m_tready_i(m_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .outcome_o (outcome),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  assign m_axis_tdata = {6'b000000, outcome};

endmodule

// ===== verif/grid_line_of_sight_check_tb.sv =====
`timescale 1ns / 100ps

module grid_line_of_sight_check_tb;
  import glos_pkg::*;

  localparam int GRID_SIDE   = 256;
  localparam int SETTLE_CYC  = 300;
  localparam int DRAIN_LIMIT = 200000;
  localparam int MAX_REPORTS = 20;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [8:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  bit          occ_grid [GRID_SIDE*GRID_SIDE];
  int unsigned width_cfg  = 256;
  int unsigned height_cfg = 256;
  outcome_e    outcome_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_items        = 0;
  int n_writes       = 0;
  int n_queries      = 0;
  int n_checked      = 0;
  int n_errors       = 0;

  grid_line_of_sight_check #(
    .GRID_SIDE(GRID_SIDE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("timeout: block stopped responding");
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic bit cell_set(input int x, input int y);
    if (x < 0 || y < 0 || x >= GRID_SIDE || y >= GRID_SIDE) begin
      return 1'b0;
    end
    return occ_grid[x*GRID_SIDE + y];
  endfunction

  // a is the major axis, walked upward; b follows by the error term
  function automatic bit walk_hits(input int a1, input int a2, input int b1, input int db,
                                   input int sb, input bit swapped);
    int da;
    int d;
    int b;
    da = a2 - a1;
    d  = 2*db - da;
    b  = b1;
    for (int a = a1; a <= a2; a++) begin
      if (swapped ? cell_set(b, a) : cell_set(a, b)) begin
        return 1'b1;
      end
      if (d <= 0) begin
        d += 2*db;
      end else begin
        d += 2*db - 2*da;
        b += sb;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit line_hits(input int x1, input int y1, input int x2, input int y2);
    int adx;
    int ady;
    adx = (x2 > x1) ? x2 - x1 : x1 - x2;
    ady = (y2 > y1) ? y2 - y1 : y1 - y2;
    if (ady <= adx) begin
      if (x1 > x2) begin
        return walk_hits(x2, x1, y2, ady, (y1 < y2) ? -1 : 1, 1'b0);
      end
      return walk_hits(x1, x2, y1, ady, (y2 < y1) ? -1 : 1, 1'b0);
    end
    if (y1 > y2) begin
      return walk_hits(y2, y1, x2, adx, (x1 < x2) ? -1 : 1, 1'b1);
    end
    return walk_hits(y1, y2, x1, adx, (x2 < x1) ? -1 : 1, 1'b1);
  endfunction

  function automatic outcome_e predict_query(input logic [7:0] sx, input logic [7:0] sy,
                                             input logic [9:0] ex, input logic [9:0] ey);
    int w;
    int h;
    int exi;
    int eyi;
    w   = (width_cfg > GRID_SIDE) ? GRID_SIDE : int'(width_cfg);
    h   = (height_cfg > GRID_SIDE) ? GRID_SIDE : int'(height_cfg);
    exi = $signed(ex);
    eyi = $signed(ey);
    if (exi < 0 || exi >= w || eyi < 0 || eyi >= h) begin
      return OUT_OFF_GRID;
    end
    return line_hits(int'(sx), int'(sy), exi, eyi) ? OUT_BLOCKED : OUT_CLEAR;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] sx, input logic [7:0] sy,
                           input logic [9:0] ex, input logic [9:0] ey, input logic cv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, cv, ey, ex, sy, sx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_items++;
    if (op == OPC_WRITE) begin
      n_writes++;
      if (sx < GRID_SIDE && sy < GRID_SIDE) begin
        occ_grid[int'(sx)*GRID_SIDE + int'(sy)] = cv;
      end
    end else begin
      n_queries++;
      outcome_q.insert(outcome_q.size(), predict_query(sx, sy, ex, ey));
    end
  endtask

  // end fields are don't-care on a write; fill them with noise
  task automatic send_write(input int x, input int y, input bit v);
    send_item(OPC_WRITE, 8'(x), 8'(y), 10'($urandom), 10'($urandom), v);
  endtask

  task automatic send_query(input int sx, input int sy, input int ex, input int ey);
    send_item(OPC_QUERY, 8'(sx), 8'(sy), 10'(ex), 10'(ey), 1'($urandom));
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (outcome_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (outcome_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
      outcome_q.delete();
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 9'(val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_IDX_WIDTH) begin
      width_cfg = val & 9'h1FF;
    end else begin
      height_cfg = val & 9'h1FF;
    end
  endtask

  always @(posedge clk_i) begin
    outcome_e want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("result %0h with nothing pending", m_axis_tdata));
      end else begin
        want = outcome_q.pop_front();
        n_checked++;
        if (m_axis_tdata !== {6'd0, want}) begin
          report_mismatch($sformatf("outcome %0h, expected %s", m_axis_tdata, want.name()));
        end
      end
    end
  end

  task automatic test_directed_walks();
    send_query(0, 0, 0, 0);
    send_write(0, 0, 1'b1);
    send_query(0, 0, 0, 0);
    send_query(3, 0, 0, 0);
    send_write(0, 0, 1'b0);
    send_write(5, 0, 1'b1);
    send_query(0, 0, 9, 0);
    send_query(9, 0, 0, 0);
    send_write(7, 3, 1'b1);
    send_query(7, 0, 7, 9);
    send_query(7, 9, 7, 4);
    send_query(4, 0, 10, 6);
    send_query(2, 1, 5, 12);
    send_write(255, 255, 1'b1);
    send_query(200, 255, 255, 255);
    send_query(255, 255, 0, 0);
    send_query(0, 255, 255, 0);
    send_query(10, 10, -1, 0);
    send_query(10, 10, 0, -512);
    send_query(10, 10, 511, 511);
    send_query(10, 10, 256, 10);
    send_query(10, 10, 10, 256);
    send_write(5, 0, 1'b0);
    send_query(0, 0, 9, 0);
  endtask

  task automatic test_grid_size_limits();
    wait_idle();
    cfg_write(CFG_IDX_WIDTH, 1);
    cfg_write(CFG_IDX_HEIGHT, 1);
    send_query(100, 100, 0, 0);
    send_query(0, 0, 1, 0);
    send_query(0, 0, 0, 1);
    wait_idle();
    cfg_write(CFG_IDX_WIDTH, 0);
    cfg_write(CFG_IDX_HEIGHT, 256);
    send_query(0, 0, 0, 0);
    wait_idle();
    cfg_write(CFG_IDX_WIDTH, 256);
    cfg_write(CFG_IDX_HEIGHT, 0);
    send_query(0, 0, 0, 0);
    wait_idle();
    cfg_write(CFG_IDX_WIDTH, 511);
    cfg_write(CFG_IDX_HEIGHT, 257);
    send_query(0, 0, 255, 255);
    send_query(0, 0, 256, 0);
    wait_idle();
    cfg_write(CFG_IDX_WIDTH, 16);
    cfg_write(CFG_IDX_HEIGHT, 16);
    send_write(200, 200, 1'b1);
    send_query(200, 200, 3, 3);
    send_query(200, 190, 10, 10);
    send_query(3, 3, 16, 3);
  endtask

  // mostly near a window so obstacles actually land on walked lines
  function automatic int pick_coord(input int base);
    if ($urandom_range(99) < 80) begin
      return base + int'($urandom_range(31));
    end
    return int'($urandom_range(255));
  endfunction

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input int w, input int h);
    int base_x;
    int base_y;
    int kind;
    int sx;
    int sy;
    int dx;
    int dy;
    wait_idle();
    cfg_write(CFG_IDX_WIDTH, w);
    cfg_write(CFG_IDX_HEIGHT, h);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    base_x = $urandom_range(224);
    base_y = $urandom_range(224);
    repeat (count) begin
      kind = $urandom_range(99);
      sx   = pick_coord(base_x);
      sy   = pick_coord(base_y);
      dx   = int'($urandom_range(16)) - 8;
      dy   = int'($urandom_range(16)) - 8;
      if (kind < 35) begin
        send_write(sx, sy, $urandom_range(99) < 40);
      end else if (kind < 88) begin
        send_query(sx, sy, sx + dx, sy + dy);
      end else if (kind < 94) begin
        send_query(sx, sy, $urandom_range(255), $urandom_range(255));
      end else begin
        send_query(sx, sy, int'($urandom_range(1023)) - 512, int'($urandom_range(1023)) - 512);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_walks();
    test_grid_size_limits();
    test_random_traffic(430, 0, 0, 256, 256);
    test_random_traffic(430, 70, 0, 64, 200);
    test_random_traffic(430, 0, 70, 300, 128);
    test_random_traffic(430, 19, 19, 256, 256);

    wait_idle();
    $display("covered %0d items (%0d cell writes, %0d queries), %0d results checked",
             n_items, n_writes, n_queries, n_checked);
    $display("grid sizes from 0 to 511 under four idle/stall mixes, %0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
